FILE: rtl/cpa_pkg.sv
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared types and constants of the contiguous page allocator.
// ----------------------------------------------------------------------------
package cpa_pkg;

    localparam int COUNT_W = 11;
    localparam int PAGE_W  = 10;
    localparam int TAG_W   = 4;

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [COUNT_W-1:0] page_count;
        logic [PAGE_W-1:0]  first_page;
        logic [TAG_W-1:0]   purpose_tag;
    } t_request;

    typedef struct packed {
        logic [PAGE_W-1:0] start_index;
        logic              granted;
    } t_result;

    // Controller to datapath commands
    typedef struct packed {
        logic init_step;
        logic load_req;
        logic prep;
        logic scan_step;
        logic write_step;
        logic finish;
        logic grant;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic init_last;
        logic is_free;
        logic alloc_zero;
        logic free_empty;
        logic scan_hit;
        logic scan_end;
        logic write_last;
    } t_dp_stat;

endpackage

FILE: rtl/contiguous_page_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_page_allocator
// First-fit allocator of contiguous runs in a page directory, with free.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; exactly one
// result follows on o_result, marked by a one-cycle o_done pulse, and it
// cannot be stalled. After reset the directory is cleared one page a cycle,
// with page 0 marked used, and busy stays high until the clearing pass is
// done. An allocate reads the used-bit memory one page a cycle from page 1
// upward, up to the end of the first run that fits (at most PAGES - 1 pages
// when no run fits), and then marks the pages of that run one by one.
// A zero-length allocate answers from the check step, without a scan. A
// free writes its range page by page after clamping at the directory end.
// The single memory write port sets the write passes; the serial scan
// sets the allocate time.
// ----------------------------------------------------------------------------
module contiguous_page_allocator
    import cpa_pkg::*;
#(
    parameter int PAGES = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_request         i_request,
    input  logic             i_cfg_we,
    input  logic [TAG_W-1:0] i_cfg_wdata,
    output logic             o_done,
    output t_result          o_result
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequence the clearing pass, scan and write passes
    cpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // Hold the directory, walk it, and register the result
    cpa_datapath #(
        .PAGES (PAGES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_request   (i_request),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_result    (o_result)
    );

    // A result only appears once the controller is back at rest
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // An accepted transaction makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transaction accepted without going busy");

    // Every finish command yields exactly one result strobe
    a_finish_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.finish |=> o_done)
        else $error("finish without result strobe");

    // A refused allocation reports start index zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.granted) |-> (o_result.start_index == '0))
        else $error("failed allocation with nonzero start index");

endmodule

FILE: rtl/cpa_ctrl.sv
// ----------------------------------------------------------------------------
// cpa_ctrl
// Sequencer of the page allocator: clearing pass, scan and write passes.
// ----------------------------------------------------------------------------
module cpa_ctrl
    import cpa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_INIT  = 5'b00001,
        S_IDLE  = 5'b00010,
        S_CHECK = 5'b00100,
        S_SCAN  = 5'b01000,
        S_WRITE = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.init_step = 1'b1;
                if (i_stat.init_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.prep = 1'b1;
                if (!i_stat.is_free) begin
                    if (i_stat.alloc_zero) begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end else if (i_stat.free_empty) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.grant  = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_hit) begin
                    n_state = S_WRITE;
                end else if (i_stat.scan_end) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_WRITE: begin
                o_cmd.write_step = 1'b1;
                if (i_stat.write_last) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.grant  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

FILE: rtl/cpa_datapath.sv
// ----------------------------------------------------------------------------
// cpa_datapath
// Page directory memories, scan and write pointers, and result register.
// ----------------------------------------------------------------------------
module cpa_datapath
    import cpa_pkg::*;
#(
    parameter int PAGES = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    output t_dp_stat         o_stat,
    input  t_request         i_request,
    input  logic             i_cfg_we,
    input  logic [TAG_W-1:0] i_cfg_wdata,
    output logic             o_done,
    output t_result          o_result
);

    localparam int AW = $clog2(PAGES);
    localparam int LW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;
    localparam int EW = (AW + 1 > COUNT_W + 1) ? AW + 1 : COUNT_W + 1;

    // Page directory
    logic             r_page_used [0:PAGES-1];
    logic [TAG_W-1:0] r_page_tag  [0:PAGES-1];

    logic               r_op;
    logic [COUNT_W-1:0] r_count;
    logic [PAGE_W-1:0]  r_first;
    logic [TAG_W-1:0]   r_tag;
    logic [TAG_W-1:0]   r_avail;

    logic [AW:0]        r_addr;
    logic               r_rd_vld;
    logic [AW-1:0]      r_rd_addr;
    logic               r_used_q;
    logic [LW-1:0]      r_run_len;
    logic [AW-1:0]      r_run_start;
    logic [AW-1:0]      r_wptr;
    logic [AW:0]        r_end;
    logic [AW-1:0]      r_res_start;
    logic               r_done;
    t_result            r_result;

    logic               rd_en;
    logic               mem_we;
    logic               mem_used_d;
    logic [TAG_W-1:0]   mem_tag_d;
    logic [LW-1:0]      count_l;
    logic [LW-1:0]      run_inc;
    logic               hit;
    logic [AW-1:0]      hit_start;
    logic [LW-1:0]      hit_end;
    logic [EW-1:0]      first_ext;
    logic [EW-1:0]      free_sum;
    logic [EW-1:0]      free_end;
    logic [AW-1:0]      res_sel;
    logic [AW+PAGE_W-1:0] res_wide;

    // Scan arithmetic
    assign rd_en     = i_cmd.scan_step && (r_addr < (AW+1)'(PAGES));
    assign count_l   = LW'(r_count);
    assign run_inc   = r_run_len + LW'(1);
    assign hit       = r_rd_vld && !r_used_q && (run_inc == count_l);
    assign hit_start = (r_run_len == '0) ? r_rd_addr : r_run_start;
    assign hit_end   = LW'(hit_start) + count_l;

    // Free range, clamped at the directory end
    assign first_ext = EW'(r_first);
    assign free_sum  = first_ext + EW'(r_count);
    assign free_end  = (free_sum > EW'(PAGES)) ? EW'(PAGES) : free_sum;

    // Write port: clearing pass or run/range write
    assign mem_we     = i_cmd.init_step || i_cmd.write_step;
    assign mem_used_d = i_cmd.init_step ? (r_wptr == '0) : (r_op == OP_ALLOC);
    assign mem_tag_d  = i_cmd.init_step ? '0 : ((r_op == OP_ALLOC) ? r_tag : r_avail);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_page_used[r_wptr] <= mem_used_d;
            r_page_tag[r_wptr]  <= mem_tag_d;
        end
        if (rd_en) begin
            r_used_q <= r_page_used[r_addr[AW-1:0]];
        end
    end

    // Request capture and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avail <= '0;
        end else if (i_cfg_we) begin
            r_avail <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_op    <= i_request.operation;
            r_count <= i_request.page_count;
            r_first <= i_request.first_page;
            r_tag   <= i_request.purpose_tag;
        end
    end

    // Pointers and run tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr    <= '0;
            r_addr    <= '0;
            r_rd_vld  <= 1'b0;
            r_run_len <= '0;
        end else begin
            r_rd_vld <= rd_en;
            if (rd_en) begin
                r_addr    <= r_addr + (AW+1)'(1);
                r_rd_addr <= r_addr[AW-1:0];
            end
            if (i_cmd.prep) begin
                r_addr    <= (AW+1)'(1);
                r_run_len <= '0;
                r_wptr    <= first_ext[AW-1:0];
                r_end     <= free_end[AW:0];
            end
            if (i_cmd.scan_step && r_rd_vld) begin
                if (r_used_q) begin
                    r_run_len <= '0;
                end else begin
                    r_run_len   <= run_inc;
                    r_run_start <= hit_start;
                end
                if (hit) begin
                    r_wptr      <= hit_start;
                    r_end       <= hit_end[AW:0];
                    r_res_start <= hit_start;
                end
            end
            if (mem_we) begin
                r_wptr <= r_wptr + AW'(1);
            end
        end
    end

    // Result register
    assign res_sel  = (i_cmd.grant && (r_op == OP_ALLOC)) ? r_res_start : '0;
    assign res_wide = {{PAGE_W{1'b0}}, res_sel};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
        end
        if (i_cmd.finish) begin
            r_result.start_index <= res_wide[PAGE_W-1:0];
            r_result.granted     <= i_cmd.grant;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    assign o_stat.init_last  = (r_wptr == AW'(PAGES - 1));
    assign o_stat.is_free    = (r_op == OP_FREE);
    assign o_stat.alloc_zero = (r_count == '0);
    assign o_stat.free_empty = (free_end <= first_ext);
    assign o_stat.scan_hit   = hit;
    assign o_stat.scan_end   = r_rd_vld && !hit && (r_rd_addr == AW'(PAGES - 1));
    assign o_stat.write_last = (({1'b0, r_wptr} + (AW+1)'(1)) == r_end);

endmodule
